// ===== rtl/ils_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the indexed list store.
// No dependencies; used by every module of the block.
package ils_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_W  = 4;
    localparam int IDX_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_READ_AT = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RESIZE  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FRONT   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BACK    = 4'd8;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] ERR_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS,
        S_PUT,
        S_ERA,
        S_FILL
    } t_state;

endpackage

// ===== rtl/ils_ram.sv =====
`timescale 1ns / 1ps
// Entry storage: one write port, one read port, registered read data.
// Depends on ils_pkg for its defaults; instantiated by indexed_list_store_top.
module ils_ram #(
    parameter int DEPTH = ils_pkg::CAPACITY_DEF,
    parameter int WIDTH = ils_pkg::WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/indexed_list_store_top.sv =====
`timescale 1ns / 1ps
// Top level of the indexed list store: command sequencer, length register,
// result register. Depends on ils_pkg and ils_ram.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------
//  command | i_in_valid  | o_in_ready  | i_command i_index i_new_length i_value
//  result  | o_out_valid | i_out_ready | o_read_data o_status o_count o_is_empty
//
// Push, pop, clear, refused commands and no-op codes complete in S_IDLE.
// Read_at, front, back pass through S_READ for the registered memory read.
// Insert below the end shifts entries up in S_INS, then writes in S_PUT; erase
// before the last entry shifts down in S_ERA; resize upward fills in S_FILL.
// The single memory write port moves one entry per cycle in these states.
// Reset clears the length and the result valid flag; entries need no clearing.
// A result waiting on a stalled output blocks the next command transfer.
module indexed_list_store_top #(
    parameter int CAPACITY  = ils_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ils_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ils_pkg::CMD_W-1:0]           i_command,
    input  logic [ils_pkg::IDX_W-1:0]           i_index,
    input  logic [ils_pkg::IDX_W-1:0]           i_new_length,
    input  logic signed [ils_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ils_pkg::DATA_W-1:0]   o_read_data,
    output logic [ils_pkg::ST_W-1:0]            o_status,
    output logic [ils_pkg::IDX_W-1:0]           o_count,
    output logic                                o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > ils_pkg::IDX_W) ? LW : ils_pkg::IDX_W;

    ils_pkg::t_state r_state, n_state;
    logic [LW-1:0]        r_len, n_len;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_idx, n_idx;
    logic [WORD_BITS-1:0] r_val, n_val;
    logic                 r_out_valid, n_out_valid;
    logic [ils_pkg::DATA_W-1:0] r_rd, n_rd;
    logic [ils_pkg::ST_W-1:0]   r_st, n_st;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic [AW-1:0]        mem_ra;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 w_accept;
    logic [CW-1:0]        w_len_c, w_idx_c, w_nlen_c, w_cap_c, w_ptr_c;
    logic [63:0]          w_vwide;
    logic [WORD_BITS-1:0] w_vword;
    logic signed [WORD_BITS-1:0] w_rword;
    logic signed [63:0]   w_rext;
    logic [ils_pkg::DATA_W-1:0] w_rd32;

    ils_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state == ils_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_len_c  = CW'(r_len);
    assign w_idx_c  = CW'(i_index);
    assign w_nlen_c = CW'(i_new_length);
    assign w_cap_c  = CW'(CAPACITY);
    assign w_ptr_c  = CW'(r_ptr);

    assign w_vwide = {32'b0, i_value};
    assign w_vword = w_vwide[WORD_BITS-1:0];
    assign w_rword = $signed(mem_rdata);
    assign w_rext  = 64'(w_rword);
    assign w_rd32  = w_rext[ils_pkg::DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ils_pkg::S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        r_val <= n_val;
        r_rd  <= n_rd;
        r_st  <= n_st;
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rd        = r_rd;
        n_st        = r_st;
        mem_we      = 1'b0;
        mem_wa      = r_ptr;
        mem_wd      = r_val;
        mem_ra      = r_ptr;

        unique case (r_state)
            ils_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_st        = ils_pkg::ST_OK;
                    unique case (i_command) inside
                        ils_pkg::CMD_PUSH: begin
                            if (w_len_c >= w_cap_c) begin
                                n_st = ils_pkg::ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = r_len[AW-1:0];
                                mem_wd = w_vword;
                                n_len  = r_len + LW'(1);
                            end
                        end
                        ils_pkg::CMD_POP: begin
                            if (r_len == '0) begin
                                n_st = ils_pkg::ST_RANGE;
                            end else begin
                                n_len = r_len - LW'(1);
                            end
                        end
                        ils_pkg::CMD_CLEAR: begin
                            n_len = '0;
                        end
                        ils_pkg::CMD_READ_AT: begin
                            if (w_idx_c >= w_len_c) begin
                                n_rd = ils_pkg::ERR_WORD;
                                n_st = ils_pkg::ST_RANGE;
                            end else begin
                                mem_ra      = w_idx_c[AW-1:0];
                                n_out_valid = 1'b0;
                                n_state     = ils_pkg::S_READ;
                            end
                        end
                        ils_pkg::CMD_INSERT: begin
                            if (w_idx_c > w_len_c) begin
                                n_st = ils_pkg::ST_RANGE;
                            end else if (w_len_c >= w_cap_c) begin
                                n_st = ils_pkg::ST_FULL;
                            end else if (w_idx_c == w_len_c) begin
                                mem_we = 1'b1;
                                mem_wa = r_len[AW-1:0];
                                mem_wd = w_vword;
                                n_len  = r_len + LW'(1);
                            end else begin
                                mem_ra      = AW'(r_len - LW'(1));
                                n_ptr       = AW'(r_len - LW'(1));
                                n_idx       = w_idx_c[AW-1:0];
                                n_val       = w_vword;
                                n_len       = r_len + LW'(1);
                                n_out_valid = 1'b0;
                                n_state     = ils_pkg::S_INS;
                            end
                        end
                        ils_pkg::CMD_ERASE: begin
                            if (w_idx_c >= w_len_c) begin
                                n_st = ils_pkg::ST_RANGE;
                            end else begin
                                n_len = r_len - LW'(1);
                                if (w_idx_c != w_len_c - CW'(1)) begin
                                    mem_ra      = AW'(w_idx_c + CW'(1));
                                    n_ptr       = AW'(w_idx_c + CW'(1));
                                    n_out_valid = 1'b0;
                                    n_state     = ils_pkg::S_ERA;
                                end
                            end
                        end
                        ils_pkg::CMD_RESIZE: begin
                            if (w_nlen_c > w_cap_c) begin
                                n_st = ils_pkg::ST_FULL;
                            end else begin
                                n_len = LW'(w_nlen_c);
                                if (w_nlen_c > w_len_c) begin
                                    n_ptr       = r_len[AW-1:0];
                                    n_val       = w_vword;
                                    n_out_valid = 1'b0;
                                    n_state     = ils_pkg::S_FILL;
                                end
                            end
                        end
                        ils_pkg::CMD_FRONT, ils_pkg::CMD_BACK: begin
                            if (r_len == '0) begin
                                n_rd = ils_pkg::ERR_WORD;
                                n_st = ils_pkg::ST_RANGE;
                            end else begin
                                mem_ra      = (i_command == ils_pkg::CMD_FRONT) ? '0
                                                : AW'(r_len - LW'(1));
                                n_out_valid = 1'b0;
                                n_state     = ils_pkg::S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ils_pkg::S_READ: begin
                n_out_valid = 1'b1;
                n_rd        = w_rd32;
                n_st        = ils_pkg::ST_OK;
                n_state     = ils_pkg::S_IDLE;
            end
            ils_pkg::S_INS: begin
                mem_we = 1'b1;
                mem_wa = r_ptr + AW'(1);
                mem_wd = mem_rdata;
                if (r_ptr == r_idx) begin
                    n_state = ils_pkg::S_PUT;
                end else begin
                    mem_ra = r_ptr - AW'(1);
                    n_ptr  = r_ptr - AW'(1);
                end
            end
            ils_pkg::S_PUT: begin
                mem_we      = 1'b1;
                mem_wa      = r_idx;
                mem_wd      = r_val;
                n_out_valid = 1'b1;
                n_rd        = '0;
                n_st        = ils_pkg::ST_OK;
                n_state     = ils_pkg::S_IDLE;
            end
            ils_pkg::S_ERA: begin
                mem_we = 1'b1;
                mem_wa = r_ptr - AW'(1);
                mem_wd = mem_rdata;
                if (w_ptr_c == w_len_c) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_st        = ils_pkg::ST_OK;
                    n_state     = ils_pkg::S_IDLE;
                end else begin
                    mem_ra = r_ptr + AW'(1);
                    n_ptr  = r_ptr + AW'(1);
                end
            end
            ils_pkg::S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                mem_wd = r_val;
                if (w_ptr_c + CW'(1) == w_len_c) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_st        = ils_pkg::ST_OK;
                    n_state     = ils_pkg::S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = ils_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = $signed(r_rd);
    assign o_status    = r_st;
    assign o_count     = ils_pkg::IDX_W'(r_len);
    assign o_is_empty  = (r_len == '0);

    a_accept_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_out_valid |-> i_out_ready)
        else $error("command transfer while result slot stays occupied");

    a_busy_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ils_pkg::S_IDLE |-> !r_out_valid)
        else $error("result pending during multi-cycle command");

    a_idle_write_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && r_state == ils_pkg::S_IDLE |-> w_accept)
        else $error("memory write in idle without a command transfer");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_len_c <= w_cap_c)
        else $error("length above capacity");

    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ils_pkg::S_FILL |-> w_ptr_c < w_len_c)
        else $error("fill pointer past new length");

endmodule
